// File: design/range_scan_nearest_target_follower_unit_macros.svh
// Assertion macros shared by the range scan follower design.
// Included by the top level; depends on nothing else.
`ifndef RANGE_SCAN_NEAREST_TARGET_FOLLOWER_UNIT_MACROS_SVH
`define RANGE_SCAN_NEAREST_TARGET_FOLLOWER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSNTF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSNTF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/rsntf_pkg.sv
// Shared types and constants for the range scan nearest-target follower.
// Used by every module of the design; has no dependencies.
package rsntf_pkg;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    RegRangeFloor  = 3'd0,
    RegMaxRange    = 3'd1,
    RegFovHalf     = 3'd2,
    RegScanStart   = 3'd3,
    RegScanStep    = 3'd4,
    RegFollowDist  = 3'd5,
    RegStopDist    = 3'd6,
    RegLinGain     = 3'd7
  } reg_idx_e;

  localparam logic [15:0] RstRangeFloor  = 16'd120;
  localparam logic [15:0] RstMaxRange    = 16'd1800;
  localparam logic [14:0] RstFovHalf     = 15'd12743;
  localparam logic [15:0] RstScanStart   = 16'h8000;
  localparam logic [15:0] RstScanStep    = 16'd182;
  localparam logic [15:0] RstFollowDist  = 16'd600;
  localparam logic [15:0] RstStopDist    = 16'd350;
  localparam logic [9:0]  RstLinGain     = 10'd102;

  localparam int LinMax       = 150;
  localparam int AngMax       = 800;
  localparam int BackoffSpeed = -40;
  // 0.8 rad/s per rad, expressed as mrad/s per 1/65536 turn in Q16.
  localparam int AngGainQ16   = 5027;

  typedef struct packed {
    logic [15:0] range_floor;
    logic [15:0] max_range;
    logic [14:0] fov_half;
    logic [15:0] scan_start;
    logic [15:0] scan_step;
    logic [15:0] follow_dist;
    logic [15:0] stop_dist;
    logic [9:0]  lin_gain;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [15:0] angle;
  } start_ld_t;

  typedef struct packed {
    logic        found;
    logic [15:0] range;
    logic [15:0] angle;
  } scan_sum_t;

  typedef struct packed {
    logic [8:0]  lin;
    logic [10:0] ang;
    logic        found;
    logic [15:0] range;
    logic [15:0] angle;
  } cmd_t;

endpackage

// File: design/rsntf_regs.sv
// APB-style configuration registers of the follower.
// Depends on rsntf_pkg for the register map and the configuration struct.
module rsntf_regs import rsntf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output cfg_t             cfg_o,
  output start_ld_t        start_ld_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign wr_en = psel & penable & pwrite;
  assign idx   = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_floor  <= RstRangeFloor;
      cfg_q.max_range    <= RstMaxRange;
      cfg_q.fov_half     <= RstFovHalf;
      cfg_q.scan_start   <= RstScanStart;
      cfg_q.scan_step    <= RstScanStep;
      cfg_q.follow_dist  <= RstFollowDist;
      cfg_q.stop_dist    <= RstStopDist;
      cfg_q.lin_gain     <= RstLinGain;
    end else if (wr_en) begin
      case (idx)
        RegRangeFloor:  cfg_q.range_floor  <= pwdata[15:0];
        RegMaxRange:    cfg_q.max_range    <= pwdata[15:0];
        RegFovHalf:     cfg_q.fov_half     <= pwdata[14:0];
        RegScanStart:   cfg_q.scan_start   <= pwdata[15:0];
        RegScanStep:    cfg_q.scan_step    <= pwdata[15:0];
        RegFollowDist:  cfg_q.follow_dist  <= pwdata[15:0];
        RegStopDist:    cfg_q.stop_dist    <= pwdata[15:0];
        RegLinGain:     cfg_q.lin_gain     <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegRangeFloor:  prdata = {16'd0, cfg_q.range_floor};
      RegMaxRange:    prdata = {16'd0, cfg_q.max_range};
      RegFovHalf:     prdata = {17'd0, cfg_q.fov_half};
      RegScanStart:   prdata = {16'd0, cfg_q.scan_start};
      RegScanStep:    prdata = {16'd0, cfg_q.scan_step};
      RegFollowDist:  prdata = {16'd0, cfg_q.follow_dist};
      RegStopDist:    prdata = {16'd0, cfg_q.stop_dist};
      RegLinGain:     prdata = {22'd0, cfg_q.lin_gain};
      default:        prdata = '0;
    endcase
  end

  // A write of the start angle also restarts the beam angle on the same edge.
  assign start_ld_o.load  = wr_en && (idx == RegScanStart);
  assign start_ld_o.angle = pwdata[15:0];
  assign cfg_o            = cfg_q;

endmodule

// File: design/rsntf_tracker.sv
// Per-sample scan tracker: beam angle, field-of-view test and nearest-range update.
// Depends on rsntf_pkg for the configuration and scan summary structs.
module rsntf_tracker import rsntf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  start_ld_t   start_ld_i,
  input  logic        adv_i,
  input  logic [15:0] range_i,
  input  logic        finite_i,
  input  logic        last_i,
  output scan_sum_t   sum_o
);

  logic [15:0] beam_q;
  logic [15:0] best_range_q;
  logic [15:0] best_angle_q;
  logic        found_q;

  logic signed [16:0] ang_ext;
  logic [16:0]        mag;
  logic               in_fov;
  logic               qual;

  // The half-turn angle has magnitude 32768 and so never passes the test.
  assign ang_ext = {beam_q[15], beam_q};
  assign mag     = beam_q[15] ? 17'(-ang_ext) : 17'(ang_ext);
  assign in_fov  = mag <= {2'b00, cfg_i.fov_half};

  assign qual = finite_i && (range_i >= cfg_i.range_floor) &&
                (range_i <= cfg_i.max_range) && in_fov &&
                (!found_q || (range_i < best_range_q));

  assign sum_o.found = found_q | qual;
  assign sum_o.range = qual ? range_i : best_range_q;
  assign sum_o.angle = qual ? beam_q  : best_angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_q       <= RstScanStart;
      best_range_q <= 16'hFFFF;
      best_angle_q <= '0;
      found_q      <= 1'b0;
    end else if (start_ld_i.load) begin
      beam_q <= start_ld_i.angle;
    end else if (adv_i) begin
      if (last_i) begin
        beam_q       <= cfg_i.scan_start;
        best_range_q <= 16'hFFFF;
        best_angle_q <= '0;
        found_q      <= 1'b0;
      end else begin
        beam_q       <= beam_q + cfg_i.scan_step;
        best_range_q <= sum_o.range;
        best_angle_q <= sum_o.angle;
        found_q      <= sum_o.found;
      end
    end
  end

endmodule

// File: design/rsntf_cmd.sv
// Speed command pipeline: scan summary register, gain products, round and clamp.
// Depends on rsntf_pkg for the configuration, summary and command structs.
module rsntf_cmd import rsntf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  scan_sum_t sum_i,
  input  logic      sum_valid_i,
  output logic      sum_ready_o,
  output cmd_t      cmd_o,
  output logic      cmd_valid_o,
  input  logic      cmd_ready_i
);

  // Summary stage.
  logic      v1_q;
  scan_sum_t sum_q;
  // Product stage.
  logic               v2_q;
  logic signed [27:0] plin_q;
  logic signed [29:0] pang_q;
  logic               found2_q;
  logic               close2_q;
  logic [15:0]        range2_q;
  logic [15:0]        angle2_q;
  // Result stage.
  logic v3_q;
  cmd_t cmd_q;

  logic s1_rdy, s2_rdy, s3_rdy;

  logic signed [16:0] err;
  logic signed [27:0] plin_d;
  logic signed [29:0] pang_d;
  logic signed [27:0] lin_r;
  logic signed [29:0] ang_r;
  logic [8:0]         lin_c;
  logic [10:0]        ang_c;
  cmd_t               cmd_d;

  assign s3_rdy      = !v3_q || cmd_ready_i;
  assign s2_rdy      = !v2_q || s3_rdy;
  assign s1_rdy      = !v1_q || s2_rdy;
  assign sum_ready_o = s1_rdy;

  assign err    = $signed({1'b0, sum_q.range}) - $signed({1'b0, cfg_i.follow_dist});
  assign plin_d = 28'($signed({1'b0, cfg_i.lin_gain}) * err);
  assign pang_d = 30'($signed(sum_q.angle) * $signed(14'(AngGainQ16)));

  // Adding half an LSB and shifting arithmetically rounds halves upward.
  assign lin_r = (plin_q + 28'sd128) >>> 8;
  assign ang_r = (pang_q + 30'sd32768) >>> 16;

  always_comb begin
    if (lin_r > $signed(28'(LinMax))) begin
      lin_c = 9'(LinMax);
    end else if (lin_r < $signed(28'(-LinMax))) begin
      lin_c = 9'(-LinMax);
    end else begin
      lin_c = lin_r[8:0];
    end
    if (ang_r > $signed(30'(AngMax))) begin
      ang_c = 11'(AngMax);
    end else if (ang_r < $signed(30'(-AngMax))) begin
      ang_c = 11'(-AngMax);
    end else begin
      ang_c = ang_r[10:0];
    end
    cmd_d = '0;
    if (found2_q) begin
      cmd_d.found = 1'b1;
      cmd_d.range = range2_q;
      cmd_d.angle = angle2_q;
      if (close2_q) begin
        cmd_d.lin = 9'(BackoffSpeed);
        cmd_d.ang = '0;
      end else begin
        cmd_d.lin = lin_c;
        cmd_d.ang = ang_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        v1_q <= sum_valid_i;
      end
      if (s2_rdy) begin
        v2_q <= v1_q;
      end
      if (s3_rdy) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && sum_valid_i) begin
      sum_q <= sum_i;
    end
    if (s2_rdy && v1_q) begin
      plin_q   <= plin_d;
      pang_q   <= pang_d;
      found2_q <= sum_q.found;
      close2_q <= sum_q.range < cfg_i.stop_dist;
      range2_q <= sum_q.range;
      angle2_q <= sum_q.angle;
    end
    if (s3_rdy && v2_q) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o       = cmd_q;
  assign cmd_valid_o = v3_q;

endmodule

// File: design/range_scan_nearest_target_follower_unit.sv
// Range scan nearest-target follower. Takes one range sample per clock cycle
// unless a scan-ending sample is waiting, and tracks the nearest sample inside
// the range window and the field of view. The sample marked with tlast closes
// the scan, and its speed command is offered on the command stream after it has
// passed the input register, summary, gain products and result register. Samples
// that do not end a scan never wait on the output side; a scan-ending sample
// waits only while all three command stages are full.
// Depends on rsntf_pkg, rsntf_regs, rsntf_tracker, rsntf_cmd and the macro header.
`include "range_scan_nearest_target_follower_unit_macros.svh"

module range_scan_nearest_target_follower_unit import rsntf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Sample stream.
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [15:0]      s_axis_tdata,  // [15:0] range_mm
  input  logic             s_axis_tuser,  // [0] range_finite
  input  logic             s_axis_tlast,
  // Command stream.
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [8:0] linear_speed, [19:9] angular_speed, [35:20] target_range,
  // [51:36] target_angle, [55:52] zero
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // [0] target_found
  // Configuration port.
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t      cfg;
  start_ld_t start_ld;
  scan_sum_t sum;
  cmd_t      cmd;

  logic        v0_q;
  logic [15:0] range0_q;
  logic        finite0_q;
  logic        last0_q;
  logic        s0_adv;
  logic        sum_valid;
  logic        sum_ready;

  assign pready = 1'b1;

  // A sample leaves the input register unless it ends a scan and the
  // command pipeline cannot take the summary.
  assign s0_adv        = v0_q && (!last0_q || sum_ready);
  assign s_axis_tready = !v0_q || s0_adv;
  assign sum_valid     = s0_adv && last0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (s_axis_tready) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      range0_q  <= s_axis_tdata;
      finite0_q <= s_axis_tuser;
      last0_q   <= s_axis_tlast;
    end
  end

  rsntf_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .cfg_o      (cfg),
    .start_ld_o (start_ld)
  );

  rsntf_tracker u_tracker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .start_ld_i (start_ld),
    .adv_i      (s0_adv),
    .range_i    (range0_q),
    .finite_i   (finite0_q),
    .last_i     (last0_q),
    .sum_o      (sum)
  );

  rsntf_cmd u_cmd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .sum_i       (sum),
    .sum_valid_i (sum_valid),
    .sum_ready_o (sum_ready),
    .cmd_o       (cmd),
    .cmd_valid_o (m_axis_tvalid),
    .cmd_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, cmd.angle, cmd.range, cmd.ang, cmd.lin};
  assign m_axis_tuser = cmd.found;

  `RSNTF_ASSERT_IMP(a_no_target_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 56'd0, "command without target carries nonzero data")
  `RSNTF_ASSERT_IMP(a_speed_limits, clk_i, rst_ni, m_axis_tvalid, ($signed(m_axis_tdata[8:0]) >= -9'sd150) && ($signed(m_axis_tdata[8:0]) <= 9'sd150) && ($signed(m_axis_tdata[19:9]) >= -11'sd800) && ($signed(m_axis_tdata[19:9]) <= 11'sd800), "speed command out of range")
  `RSNTF_ASSERT_IMP(a_mid_scan_no_stall, clk_i, rst_ni, v0_q && !last0_q, s_axis_tready, "mid-scan sample stalled the input")
  `RSNTF_ASSERT_NXT(a_accept_loads, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, v0_q, "accepted sample not held in input register")

endmodule
